FILE: hw/rtl/wst_pkg.sv
// ----------------------------------------------------------------------------
// wst_pkg: shared types and constants for the window slot table
// Operation codes, sequencer states, slot reset values and the structs that
// carry slot storage write and read data.
// ----------------------------------------------------------------------------
package wst_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TAKE  = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_UPDATE = 2'd2,
        ST_RESULT = 2'd3
    } state_t;

    localparam logic [31:0]        SEQ_NONE    = 32'hFFFF_FFFF;
    localparam logic [7:0]         ANS_RESET   = 8'd32;
    localparam logic signed [31:0] ERR_RESET   = -32'sd1;
    localparam logic [4:0]         SLOTS_RESET = 5'd16;

    // write side of the slot storage
    typedef struct packed {
        logic               we_all;   // store seq, answer and error
        logic               we_seq;   // store seq only
        logic [31:0]        seq;
        logic [7:0]         ans;
        logic signed [31:0] err;
    } wst_wr_t;

    // registered read side, never-written entries show reset values
    typedef struct packed {
        logic [31:0]        seq;
        logic [7:0]         ans;
        logic signed [31:0] err;
    } wst_rd_t;

endpackage

FILE: hw/rtl/wst_slot_mem.sv
// ----------------------------------------------------------------------------
// wst_slot_mem: slot contents storage
// Sequence, answer and error memories with one write and one registered read
// port. A per-entry written bit makes untouched entries read as reset values.
// ----------------------------------------------------------------------------
module wst_slot_mem
    import wst_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  wst_wr_t       wr,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] rd_addr,
    output wst_rd_t       rd
);

    logic [31:0]        seq_mem [DEPTH];
    logic [7:0]         ans_mem [DEPTH];
    logic signed [31:0] err_mem [DEPTH];

    logic [DEPTH-1:0]   written_reg;
    logic               written_q_reg;
    logic [31:0]        seq_q_reg;
    logic [7:0]         ans_q_reg;
    logic signed [31:0] err_q_reg;

    always_ff @(posedge aclk) begin
        if (wr.we_all) begin
            seq_mem[wr_addr] <= wr.seq;
            ans_mem[wr_addr] <= wr.ans;
            err_mem[wr_addr] <= wr.err;
        end else if (wr.we_seq) begin
            seq_mem[wr_addr] <= wr.seq;
        end
        seq_q_reg <= seq_mem[rd_addr];
        ans_q_reg <= ans_mem[rd_addr];
        err_q_reg <= err_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end else begin
            if (wr.we_all) begin
                written_reg[wr_addr] <= 1'b1;
            end
            written_q_reg <= written_reg[rd_addr];
        end
    end

    assign rd.seq = written_q_reg ? seq_q_reg : SEQ_NONE;
    assign rd.ans = written_q_reg ? ans_q_reg : ANS_RESET;
    assign rd.err = written_q_reg ? err_q_reg : ERR_RESET;

endmodule

FILE: hw/rtl/window_slot_table.sv
// ----------------------------------------------------------------------------
// window_slot_table: transmit-window slot table
// Allocate, free-by-sequence, take and count operations over a slot table.
// ----------------------------------------------------------------------------
// One transaction at a time: the block takes an operation, walks the first
// slots_in_use slots (saturated to MAX_SLOTS) one slot per cycle, then applies
// the change and presents one result. From accept to result valid, an
// operation issues one read per scanned slot, drains the registered read of
// the last slot, runs one update step and loads the result once the output
// register is free. The scan loop reads one entry of the slot memory per
// cycle through its registered read port. s_ready is high only while the
// sequencer is idle, which it re-enters in the same cycle as the result is
// loaded, so a new operation is accepted only once the previous one is done.
// The result sits in an output register, so the next transaction is accepted
// while a result still waits for m_ready.
// Allocate claims the lowest non-busy slot; free matches the lowest slot whose
// stored sequence number equals s_seq_num (all ones matches a slot holding no
// number, busy or not) and clears it; take clears the lowest busy slot but
// keeps its sequence number. m_free_slots counts non-busy slots among those in
// use after the operation. On a miss, or for count-only, m_success is 0 and the
// slot fields read 0. slots_in_use (cfg_wr_data) may only be written while idle.
// ----------------------------------------------------------------------------
module window_slot_table
    import wst_pkg::*;
#(
    parameter int MAX_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [31:0]        s_seq_num,
    input  logic [7:0]         s_answer_type,
    input  logic signed [31:0] s_error_code,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_success,
    output logic [3:0]         m_slot_index,
    output logic [4:0]         m_free_slots,
    output logic [31:0]        m_slot_seq,
    output logic [7:0]         m_slot_answer_type,
    output logic signed [31:0] m_slot_error
);

    // slot index width and slot count width
    localparam int          IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int          NW    = $clog2(MAX_SLOTS + 1);
    localparam logic [31:0] MAX_W = 32'(MAX_SLOTS);

    state_t             state_reg, state_next;
    logic [4:0]         cfg_slots_reg;

    // transaction captured at accept
    op_t                op_reg, op_next;
    logic [31:0]        seq_reg, seq_next;
    logic [7:0]         ans_reg, ans_next;
    logic signed [31:0] err_reg, err_next;
    logic [NW-1:0]      n_reg, n_next;

    // scan loop: issue stage walks busy flags, check stage sees memory data
    logic [NW-1:0]      iss_reg, iss_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IW-1:0]      chk_idx_reg, chk_idx_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      hit_reg, hit_next;
    logic               hit_busy_reg, hit_busy_next;
    logic [NW-1:0]      cnt_reg, cnt_next;

    logic [MAX_SLOTS-1:0] busy_reg, busy_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic               res_success_reg, res_success_next;
    logic [3:0]         res_index_reg, res_index_next;
    logic [4:0]         res_free_reg, res_free_next;
    logic [31:0]        res_seq_reg, res_seq_next;
    logic [7:0]         res_ans_reg, res_ans_next;
    logic signed [31:0] res_err_reg, res_err_next;

    // slot memory interface
    wst_wr_t            mem_wr;
    logic [IW-1:0]      mem_rd_addr;
    wst_rd_t            mem_rd;

    logic [31:0]        cfg_ext;
    logic [NW-1:0]      n_sat;
    logic               issue_ok;
    logic               busy_iss;
    logic               scan_done;
    logic               out_free;

    wst_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW)
    ) u_slot_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mem_wr),
        .wr_addr (hit_reg),
        .rd_addr (mem_rd_addr),
        .rd      (mem_rd)
    );

    // slots in use, saturated to the table size
    assign cfg_ext   = {27'b0, cfg_slots_reg};
    assign n_sat     = (cfg_ext > MAX_W) ? MAX_W[NW-1:0] : cfg_ext[NW-1:0];

    assign issue_ok  = (iss_reg < n_reg);
    assign busy_iss  = busy_reg[iss_reg[IW-1:0]];
    assign scan_done = !issue_ok && !chk_vld_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // ---- sequencer: next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb begin
        s_ready     = 1'b0;
        mem_rd_addr = hit_reg;
        mem_wr      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                mem_rd_addr = iss_reg[IW-1:0];
            end
            ST_UPDATE: begin
                // read at hit sees contents before the write, fine for free/take
                mem_wr.seq = seq_reg;
                mem_wr.ans = ans_reg;
                mem_wr.err = err_reg;
                if (found_reg && op_reg == OP_ALLOC) begin
                    mem_wr.we_all = 1'b1;
                end
                if (found_reg && op_reg == OP_FREE) begin
                    mem_wr.we_seq = 1'b1;
                    mem_wr.seq    = SEQ_NONE;
                end
            end
            ST_RESULT: begin
                mem_rd_addr = hit_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---- datapath ----
    always_comb begin
        op_next          = op_reg;
        seq_next         = seq_reg;
        ans_next         = ans_reg;
        err_next         = err_reg;
        n_next           = n_reg;
        iss_next         = iss_reg;
        chk_vld_next     = chk_vld_reg;
        chk_idx_next     = chk_idx_reg;
        found_next       = found_reg;
        hit_next         = hit_reg;
        hit_busy_next    = hit_busy_reg;
        cnt_next         = cnt_reg;
        busy_next        = busy_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        res_success_next = res_success_reg;
        res_index_next   = res_index_reg;
        res_free_next    = res_free_reg;
        res_seq_next     = res_seq_reg;
        res_ans_next     = res_ans_reg;
        res_err_next     = res_err_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = op_t'(s_op);
                    seq_next      = s_seq_num;
                    ans_next      = s_answer_type;
                    err_next      = s_error_code;
                    n_next        = n_sat;
                    iss_next      = '0;
                    chk_vld_next  = 1'b0;
                    chk_idx_next  = '0;
                    found_next    = 1'b0;
                    hit_next      = '0;
                    hit_busy_next = 1'b0;
                    cnt_next      = '0;
                end
            end
            ST_SCAN: begin
                chk_vld_next = issue_ok;
                chk_idx_next = iss_reg[IW-1:0];
                if (issue_ok) begin
                    iss_next = iss_reg + 1'b1;
                    cnt_next = cnt_reg + NW'(!busy_iss);
                    if (!found_reg && ((op_reg == OP_ALLOC && !busy_iss) ||
                                       (op_reg == OP_TAKE && busy_iss))) begin
                        found_next = 1'b1;
                        hit_next   = iss_reg[IW-1:0];
                    end
                end
                // free matches in the cycle after the issue, on registered memory data
                if (chk_vld_reg && !found_reg && op_reg == OP_FREE &&
                    mem_rd.seq == seq_reg) begin
                    found_next    = 1'b1;
                    hit_next      = chk_idx_reg;
                    hit_busy_next = busy_reg[chk_idx_reg];
                end
            end
            ST_UPDATE: begin
                if (found_reg) begin
                    case (op_reg)
                        OP_ALLOC: begin
                            busy_next[hit_reg] = 1'b1;
                            cnt_next           = cnt_reg - 1'b1;
                        end
                        OP_FREE: begin
                            busy_next[hit_reg] = 1'b0;
                            cnt_next           = cnt_reg + NW'(hit_busy_reg);
                        end
                        OP_TAKE: begin
                            busy_next[hit_reg] = 1'b0;
                            cnt_next           = cnt_reg + 1'b1;
                        end
                        default: begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    res_success_next = found_reg;
                    res_free_next    = 5'(cnt_reg);
                    res_index_next   = '0;
                    res_seq_next     = '0;
                    res_ans_next     = '0;
                    res_err_next     = '0;
                    if (found_reg) begin
                        res_index_next = 4'(hit_reg);
                        res_seq_next   = mem_rd.seq;
                        res_ans_next   = mem_rd.ans;
                        res_err_next   = mem_rd.err;
                        if (op_reg == OP_ALLOC) begin
                            res_seq_next = seq_reg;
                            res_ans_next = ans_reg;
                            res_err_next = err_reg;
                        end
                        if (op_reg == OP_FREE) begin
                            res_seq_next = SEQ_NONE;
                        end
                    end
                end
            end
            default: begin
                found_next = found_reg;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_slots_reg <= SLOTS_RESET;
            busy_reg      <= '0;
            m_valid_reg   <= 1'b0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            iss_reg       <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                cfg_slots_reg <= cfg_wr_data;
            end
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            iss_reg     <= iss_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        seq_reg         <= seq_next;
        ans_reg         <= ans_next;
        err_reg         <= err_next;
        chk_idx_reg     <= chk_idx_next;
        hit_reg         <= hit_next;
        hit_busy_reg    <= hit_busy_next;
        res_success_reg <= res_success_next;
        res_index_reg   <= res_index_next;
        res_free_reg    <= res_free_next;
        res_seq_reg     <= res_seq_next;
        res_ans_reg     <= res_ans_next;
        res_err_reg     <= res_err_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_success          = res_success_reg;
    assign m_slot_index       = res_index_reg;
    assign m_free_slots       = res_free_reg;
    assign m_slot_seq         = res_seq_reg;
    assign m_slot_answer_type = res_ans_reg;
    assign m_slot_error       = res_err_reg;

`ifndef SYNTHESIS
    // free count never exceeds the slots scanned
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= n_reg)
        else $error("free count above slots in use");

    // busy flags only move in the update step
    a_busy_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> $stable(busy_reg))
        else $error("busy flags changed outside update");

    // a miss reports zero slot fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_success_reg) |->
            (res_index_reg == 4'd0 && res_seq_reg == 32'd0 && res_ans_reg == 8'd0))
        else $error("miss with nonzero slot fields");

    // accepted transaction closes the input until the result is loaded
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted during scan");
`endif

endmodule
